// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("assertion failed");

`define ASSERT_ALWAYS(label, clk_sig, prop) \
	label: assert property (@(posedge clk_sig) prop) else $error("assertion failed");

`endif

// ===== rtl/core/eau_pkg.sv =====
// ----------------------------------------------------------------------------
// eau_pkg
// Constants, types and helpers for the Euler angle unitary pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package eau_pkg;
	localparam int DEF_ANGLE_WIDTH   = 20;
	localparam int DEF_OUT_WIDTH     = 16;
	localparam int DEF_CORDIC_STAGES = 16;
	localparam int CMD_WIDTH  = 3;
	localparam int AXIS_WIDTH = 16;
	// Q.30 working values, with headroom for products of sums.
	localparam int QW = 36;
	localparam int ZW = 38;

	typedef enum logic [2:0] {
		CMD_ZX   = 3'd0,
		CMD_ZY   = 3'd1,
		CMD_XY   = 3'd2,
		CMD_ZYX  = 3'd3,
		CMD_AXIS = 3'd4
	} cmd_t;

	localparam logic signed [ZW-1:0] PI_Q30      = 38'sd3373259426;
	localparam logic signed [ZW-1:0] TWO_PI_Q30  = 38'sd6746518852;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 38'sd1686629713;
	localparam logic signed [QW-1:0] CORDIC_K_Q30 = 36'sd652032874;

	function automatic logic signed [ZW-1:0] atan_q30(input int i);
		logic [31:0] t;
		unique case (i)
			0: t = 32'h3243F6A8;  1: t = 32'h1DAC6705;  2: t = 32'h0FADBAFC;
			3: t = 32'h07F56EA6;  4: t = 32'h03FEAB76;  5: t = 32'h01FFD55B;
			6: t = 32'h00FFFAAA;  7: t = 32'h007FFF55;  8: t = 32'h003FFFEA;
			9: t = 32'h001FFFFD;  10: t = 32'h000FFFFF; 11: t = 32'h0007FFFF;
			12: t = 32'h0003FFFF; 13: t = 32'h0001FFFF; 14: t = 32'h0000FFFF;
			15: t = 32'h00007FFF; 16: t = 32'h00003FFF; 17: t = 32'h00001FFF;
			18: t = 32'h00000FFF; 19: t = 32'h000007FF; 20: t = 32'h000003FF;
			21: t = 32'h000001FF; 22: t = 32'h000000FF; 23: t = 32'h0000007F;
			24: t = 32'h0000003F; 25: t = 32'h0000001F; 26: t = 32'h0000000F;
			27: t = 32'h00000007; 28: t = 32'h00000003; 29: t = 32'h00000001;
			default: t = 32'h0;
		endcase
		return signed'({{(ZW-32){1'b0}}, t});
	endfunction

	// Q.30 product rounded half up back to Q.30.
	function automatic logic signed [QW-1:0] qmul(input logic signed [QW-1:0] a,
			input logic signed [QW-1:0] b);
		logic signed [2*QW-1:0] p;
		p = a * b + (72'sd1 <<< 29);
		return QW'(p >>> 30);
	endfunction

	// Items that travel down the pipeline beside the data.
	typedef struct packed {
		logic [CMD_WIDTH-1:0] cmd;
	} eau_ctl_t;
endpackage
`default_nettype wire

// ===== rtl/core/euler_angles_to_unitary_top.sv =====
// ----------------------------------------------------------------------------
// euler_angles_to_unitary_top
// Throughput: one item per cycle; the pipeline advances whenever the output
// register is free or being taken, so a stall holds every stage in place.
// Reset: arst_n clears all valid bits asynchronously; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module euler_angles_to_unitary_top import eau_pkg::*; #(
	parameter int ANGLE_WIDTH   = DEF_ANGLE_WIDTH,
	parameter int OUT_WIDTH     = DEF_OUT_WIDTH,
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  wire clk,
	input  wire arst_n,
	input  wire s_axis_tvalid,
	output logic s_axis_tready,
	// command, phase_angle, first_angle, last_angle, middle_angle,
	// axis_x, axis_y, axis_z (lowest bits first), zero filled to bytes
	input  wire [((3+4*ANGLE_WIDTH+48+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  wire m_axis_tready,
	// top_left_re, top_left_im, top_right_re, top_right_im,
	// bottom_left_re, bottom_left_im, bottom_right_re, bottom_right_im
	output logic [((8*OUT_WIDTH+7)/8)*8-1:0] m_axis_tdata
);
	localparam int AW = ANGLE_WIDTH;
	localparam int HW = AW + 3;
	localparam int SH = 29 - (AW - 4);
	localparam int NT = 5;
	localparam int CL = CORDIC_STAGES + 4;
	localparam int OF = OUT_WIDTH - 2;
	localparam int LAT = CL + 5;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;

	// Unpack.
	logic [CMD_WIDTH-1:0] cmd;
	logic signed [AW-1:0] al, be, de, ga;
	logic signed [AXIS_WIDTH-1:0] ax, ay, az;
	assign cmd = s_axis_tdata[2:0];
	assign al = s_axis_tdata[3 +: AW];
	assign be = s_axis_tdata[3+AW +: AW];
	assign de = s_axis_tdata[3+2*AW +: AW];
	assign ga = s_axis_tdata[3+3*AW +: AW];
	assign ax = s_axis_tdata[3+4*AW +: 16];
	assign ay = s_axis_tdata[3+4*AW+16 +: 16];
	assign az = s_axis_tdata[3+4*AW+32 +: 16];

	// Arguments in half units; trig slot 0 always gamma.
	logic signed [HW-1:0] args [NT];
	always_comb begin
		logic signed [HW-1:0] a2, b, d;
		a2 = HW'(al) <<< 1;
		b = HW'(be);
		d = HW'(de);
		args[0] = HW'(ga);
		args[1] = '0; args[2] = '0; args[3] = '0; args[4] = '0;
		unique case (cmd)
			CMD_ZX, CMD_ZY: begin
				args[1] = a2 - b - d; args[2] = a2 - b + d;
				args[3] = a2 + b - d; args[4] = a2 + b + d;
			end
			CMD_XY: begin
				args[1] = a2; args[2] = b + d; args[3] = b - d;
			end
			CMD_ZYX: begin
				args[1] = a2 - b; args[2] = a2 + b; args[3] = d;
			end
			default: ;
		endcase
	end

	logic signed [QW-1:0] tc [NT];
	logic signed [QW-1:0] ts [NT];
	for (genvar t = 0; t < NT; t++) begin : g_trig
		eau_cordic #(.HALF_WIDTH(HW), .SHIFT(SH), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
			.clk(clk), .en(en), .half(args[t]),
			.cos_q(tc[t]), .sin_q(ts[t])
		);
	end

	// Side data delayed to match the CORDIC.
	eau_ctl_t ctl_d [CL+1];
	logic signed [QW-1:0] axd [3][CL+1];
	assign ctl_d[0].cmd = cmd;
	assign axd[0][0] = QW'(ax) <<< 16;
	assign axd[1][0] = QW'(ay) <<< 16;
	assign axd[2][0] = QW'(az) <<< 16;
	for (genvar k = 0; k < CL; k++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				ctl_d[k+1] <= ctl_d[k];
				axd[0][k+1] <= axd[0][k];
				axd[1][k+1] <= axd[1][k];
				axd[2][k+1] <= axd[2][k];
			end
		end
	end

	// Stage A: first products (one multiplier level).
	logic [CMD_WIDTH-1:0] cmd_s1;
	logic signed [QW-1:0] vr_s1, vi_s1, p_s1 [4];
	logic signed [QW-1:0] er_s1 [NT], ei_s1 [NT];
	always_ff @(posedge clk) begin
		if (en) begin
			logic [CMD_WIDTH-1:0] c;
			c = ctl_d[CL].cmd;
			cmd_s1 <= c;
			vr_s1 <= tc[0];
			vi_s1 <= ts[0];
			for (int t = 0; t < NT; t++) begin
				er_s1[t] <= tc[t];
				ei_s1[t] <= ts[t];
			end
			if (c == CMD_AXIS) begin
				p_s1[0] <= qmul(ts[0], axd[0][CL]);
				p_s1[1] <= qmul(ts[0], axd[1][CL]);
				p_s1[2] <= qmul(ts[0], axd[2][CL]);
				p_s1[3] <= '0;
			end else if (c == CMD_XY) begin
				p_s1[0] <= qmul(tc[0], tc[2]);
				p_s1[1] <= qmul(ts[0], ts[3]);
				p_s1[2] <= qmul(ts[0], tc[3]);
				p_s1[3] <= qmul(tc[0], ts[2]);
			end else begin
				p_s1[0] <= qmul(tc[0], tc[3]);
				p_s1[1] <= qmul(ts[0], ts[3]);
				p_s1[2] <= qmul(ts[0], tc[3]);
				p_s1[3] <= qmul(tc[0], ts[3]);
			end
		end
	end

	// Stage B: form the right factors and left exponentials per entry.
	logic [CMD_WIDTH-1:0] cmd_s2;
	logic signed [QW-1:0] lr_s2 [4], li_s2 [4], rr_s2 [4], ri_s2 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [QW-1:0] cc, ss, sc, cs;
			logic signed [QW-1:0] lr [4], li [4], rr [4], ri [4];
			cc = p_s1[0]; ss = p_s1[1]; sc = p_s1[2]; cs = p_s1[3];
			for (int k = 0; k < 4; k++) begin
				lr[k] = '0; li[k] = '0; rr[k] = '0; ri[k] = '0;
			end
			unique case (cmd_s1)
				CMD_ZX, CMD_ZY: begin
					for (int k = 0; k < 4; k++) begin
						lr[k] = er_s1[k+1];
						li[k] = ei_s1[k+1];
					end
					rr[0] = vr_s1; rr[3] = vr_s1;
					if (cmd_s1 == CMD_ZX) begin
						ri[1] = -vi_s1; ri[2] = -vi_s1;
					end else begin
						rr[1] = -vi_s1; rr[2] = vi_s1;
					end
				end
				CMD_XY: begin
					for (int k = 0; k < 4; k++) begin
						lr[k] = er_s1[1];
						li[k] = ei_s1[1];
					end
					rr[0] = cc;  ri[0] = -ss;
					rr[1] = -sc; ri[1] = -cs;
					rr[2] = sc;  ri[2] = -cs;
					rr[3] = cc;  ri[3] = ss;
				end
				CMD_ZYX: begin
					lr[0] = er_s1[1]; li[0] = ei_s1[1];
					lr[1] = er_s1[1]; li[1] = ei_s1[1];
					lr[2] = er_s1[2]; li[2] = ei_s1[2];
					lr[3] = er_s1[2]; li[3] = ei_s1[2];
					rr[0] = cc;  ri[0] = ss;
					rr[1] = -sc; ri[1] = -cs;
					rr[2] = sc;  ri[2] = -cs;
					rr[3] = cc;  ri[3] = -ss;
				end
				CMD_AXIS: begin
					// Direct values carried in the right factor.
					rr[0] = p_s1[2];  ri[0] = vr_s1;
					rr[1] = p_s1[0];  ri[1] = -p_s1[1];
					rr[2] = p_s1[0];  ri[2] = p_s1[1];
					rr[3] = -p_s1[2]; ri[3] = vr_s1;
				end
				default: ;
			endcase
			cmd_s2 <= cmd_s1;
			for (int k = 0; k < 4; k++) begin
				lr_s2[k] <= lr[k]; li_s2[k] <= li[k];
				rr_s2[k] <= rr[k]; ri_s2[k] <= ri[k];
			end
		end
	end

	// Stage C: complex products.
	logic [CMD_WIDTH-1:0] cmd_s3;
	logic signed [QW-1:0] prr_s3 [4], pii_s3 [4], pri_s3 [4], pir_s3 [4];
	logic signed [QW-1:0] dr_s3 [4], di_s3 [4];
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3 <= cmd_s2;
			for (int k = 0; k < 4; k++) begin
				prr_s3[k] <= qmul(lr_s2[k], rr_s2[k]);
				pii_s3[k] <= qmul(li_s2[k], ri_s2[k]);
				pri_s3[k] <= qmul(lr_s2[k], ri_s2[k]);
				pir_s3[k] <= qmul(li_s2[k], rr_s2[k]);
				dr_s3[k] <= rr_s2[k];
				di_s3[k] <= ri_s2[k];
			end
		end
	end

	// Stage D: sums, or the direct values for axis commands.
	logic signed [QW-1:0] v_s4 [8];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				if (cmd_s3 == CMD_AXIS) begin
					v_s4[2*k] <= dr_s3[k];
					v_s4[2*k+1] <= di_s3[k];
				end else begin
					v_s4[2*k] <= prr_s3[k] - pii_s3[k];
					v_s4[2*k+1] <= pri_s3[k] + pir_s3[k];
				end
			end
		end
	end

	// Stage E: round and saturate into the output register.
	function automatic logic [OUT_WIDTH-1:0] to_out(input logic signed [QW-1:0] v);
		logic signed [QW-1:0] r;
		logic signed [QW-1:0] lim;
		lim = QW'(1) <<< OF;
		if (30 - OF > 0) r = (v + (QW'(1) <<< (29 - OF))) >>> (30 - OF);
		else r = v;
		if (r > lim) r = lim;
		if (r < -lim) r = -lim;
		return r[OUT_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 8; k++) m_axis_tdata[k*OUT_WIDTH +: OUT_WIDTH] <= to_out(v_s4[k]);
		end
	end

	// Valid bits; result shows in the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
		end
	end
	assign m_axis_tvalid = vld_q[LAT-1];

	`ASSERT_CLK(a_stall_holds, clk, arst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
	`ASSERT_CLK(a_ready_free, clk, arst_n, !m_axis_tvalid |-> s_axis_tready)
	`ASSERT_CLK(a_no_invent, clk, arst_n, (en && !vld_q[LAT-2]) |=> !m_axis_tvalid)
endmodule
`default_nettype wire

// ===== rtl/core/eau_cordic.sv =====
// ----------------------------------------------------------------------------
// eau_cordic
// Pipelined sine and cosine: three range reduction stages, then one CORDIC
// iteration per register stage.
// ----------------------------------------------------------------------------
`default_nettype none
module eau_cordic import eau_pkg::*; #(
	parameter int HALF_WIDTH    = 23,
	parameter int SHIFT         = 13,
	parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
	input  wire                          clk,
	input  wire                          en,
	input  wire signed [HALF_WIDTH-1:0]  half,
	output logic signed [QW-1:0]         cos_q,
	output logic signed [QW-1:0]         sin_q
);
	// Full Q.30 argument is half << SHIFT.
	localparam int AW = HALF_WIDTH + 30;
	localparam logic signed [AW-1:0] TWO_PI_W  = AW'(TWO_PI_Q30);
	localparam logic signed [AW-1:0] FOUR_PI_W = TWO_PI_W <<< 1;
	localparam logic signed [ZW-1:0] WRAP_HI   = TWO_PI_Q30 - HALF_PI_Q30;
	logic signed [AW-1:0] arg;
	logic signed [3:0]    quo;
	logic signed [AW-1:0] red_s0;
	logic signed [ZW-1:0] w_s1;
	logic signed [ZW-1:0] z_s2;
	logic                 neg_s2;

	// The argument never exceeds 2^34 in magnitude, so a quotient estimate by
	// shift (2*pi > 4) leaves a remainder within two periods of the target range.
	assign arg = AW'(half) <<< SHIFT;
	assign quo = 4'(arg >>> 32);

	always_ff @(posedge clk) begin
		if (en) begin
			red_s0 <= arg - AW'(quo) * TWO_PI_W;
		end
	end

	// Bring the remainder into [0, 2*pi) with parallel candidate corrections.
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (red_s0 < -TWO_PI_W) w_s1 <= ZW'(red_s0 + FOUR_PI_W);
			else if (red_s0 < 0) w_s1 <= ZW'(red_s0 + TWO_PI_W);
			else if (red_s0 < TWO_PI_W) w_s1 <= ZW'(red_s0);
			else if (red_s0 < FOUR_PI_W) w_s1 <= ZW'(red_s0 - TWO_PI_W);
			else w_s1 <= ZW'(red_s0 - FOUR_PI_W);
		end
	end

	// Fold into [-pi/2, pi/2]; the middle half turn flips both results.
	always_ff @(posedge clk) begin
		if (en) begin
			priority if (w_s1 <= HALF_PI_Q30) begin
				z_s2 <= w_s1;
				neg_s2 <= 1'b0;
			end else if (w_s1 < WRAP_HI) begin
				z_s2 <= w_s1 - PI_Q30;
				neg_s2 <= 1'b1;
			end else begin
				z_s2 <= w_s1 - TWO_PI_Q30;
				neg_s2 <= 1'b0;
			end
		end
	end

	logic signed [QW-1:0] x_st [CORDIC_STAGES+1];
	logic signed [QW-1:0] y_st [CORDIC_STAGES+1];
	logic signed [ZW-1:0] z_st [CORDIC_STAGES+1];
	logic                 n_st [CORDIC_STAGES+1];
	assign x_st[0] = CORDIC_K_Q30;
	assign y_st[0] = '0;
	assign z_st[0] = z_s2;
	assign n_st[0] = neg_s2;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_st[i][ZW-1]) begin
					x_st[i+1] <= x_st[i] - (y_st[i] >>> i);
					y_st[i+1] <= y_st[i] + (x_st[i] >>> i);
					z_st[i+1] <= z_st[i] - atan_q30(i);
				end else begin
					x_st[i+1] <= x_st[i] + (y_st[i] >>> i);
					y_st[i+1] <= y_st[i] - (x_st[i] >>> i);
					z_st[i+1] <= z_st[i] + atan_q30(i);
				end
				n_st[i+1] <= n_st[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q <= n_st[CORDIC_STAGES] ? -x_st[CORDIC_STAGES] : x_st[CORDIC_STAGES];
			sin_q <= n_st[CORDIC_STAGES] ? -y_st[CORDIC_STAGES] : y_st[CORDIC_STAGES];
		end
	end
endmodule
`default_nettype wire
